/* hdl/l1wt_pkg.sv */
// Shared types and codes for the write-through L1 line coherence controller.
`default_nettype none

package l1wt_pkg;

   // Incoming event kind as carried on the request beat
   typedef enum logic [2:0] {
      CMD_READ  = 3'd0,
      CMD_WRITE = 3'd1,
      CMD_RESP  = 3'd2,
      CMD_INV   = 3'd3,
      CMD_WCOMP = 3'd4,
      CMD_REPL  = 3'd5
   } cmd_type;

   // Line states
   typedef enum logic [2:0] {
      LS_NOT_PRESENT = 3'd0,
      LS_INVALID     = 3'd1,
      LS_INV_TO_SH   = 3'd2,
      LS_SHARED      = 3'd3,
      LS_SH_TO_INV   = 3'd4,
      LS_PEND_WRITE  = 3'd5
   } line_type;

   // Line allocator answer
   typedef enum logic [1:0] {
      INS_OK    = 2'd0,
      INS_RETRY = 2'd1,
      INS_WAIT  = 2'd2
   } ins_type;

   typedef enum logic [1:0] {
      STALL_NONE = 2'd0,
      STALL_POLL = 2'd1,
      STALL_WAIT = 2'd2
   } stall_type;

   typedef enum logic [2:0] {
      DN_NONE   = 3'd0,
      DN_READ   = 3'd1,
      DN_READX  = 3'd2,
      DN_REPL   = 3'd3,
      DN_INVACK = 3'd4
   } down_type;

   typedef enum logic [1:0] {
      UP_NONE = 2'd0,
      UP_DATA = 2'd1,
      UP_INVN = 2'd2
   } up_type;

   // Event after thread-state classification
   typedef enum logic [3:0] {
      EV_LD, EV_ST, EV_RESP, EV_INV, EV_WC, EV_REPL,
      EV_TLD, EV_TST, EV_TRESP, EV_BAD
   } ev_type;

   typedef struct packed {
      logic [2:0] command;
      logic [2:0] line_state;
      logic       thread_state;
      logic [1:0] insert_status;
      logic       mshr_free;
      logic       mshr_queue_room;
      logic       prefetch_req;
   } req_type;

   typedef struct packed {
      logic [2:0] line_next;
      logic [1:0] stall_res;
      logic       protocol_error;
      logic [2:0] down_msg;
      logic       down_addr_only;
      logic [1:0] up_msg;
      logic       insert_line;
      logic       mshr_alloc;
      logic       enqueue_mshr;
      logic       fill_and_drain;
      logic       release_writeback;
      logic       prefetch_mark;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/l1_write_through_coherence_fsm.sv */
// Top level: request register, line decision, result register, bypass control register.
// An accepted request beat is held in the request register, then decided into the result register.
// Throughput: one beat per cycle; the request register takes a beat whenever it is empty
// or its beat moves on, so it blocks only while both registers are full and the result waits.
// Reset (synchronous, active high) empties both registers and clears tstate_bypass.
`default_nettype none

module l1_write_through_coherence_fsm
   import l1wt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] command
   input  logic [2:0]  req_tuser,
   // [2:0] line_state, [3] thread_state, [5:4] insert_status, [6] mshr_free,
   // [7] mshr_queue_room, [8] prefetch_req, [15:9] zero
   input  logic [15:0] req_tdata,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] line_next, [4:3] stall_res, [5] protocol_error, [8:6] down_msg,
   // [9] down_addr_only, [11:10] up_msg, [12] insert_line, [13] mshr_alloc,
   // [14] enqueue_mshr, [15] fill_and_drain, [16] release_writeback,
   // [17] prefetch_mark, [23:18] zero
   output logic [23:0] rsp_tdata,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_req_ff, s1_req_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    bypass_ff, bypass_in;
   logic    rsp_free;
   req_type req_beat;
   rsp_type decided;

   assign req_beat.command         = req_tuser;
   assign req_beat.line_state      = req_tdata[2:0];
   assign req_beat.thread_state    = req_tdata[3];
   assign req_beat.insert_status   = req_tdata[5:4];
   assign req_beat.mshr_free       = req_tdata[6];
   assign req_beat.mshr_queue_room = req_tdata[7];
   assign req_beat.prefetch_req    = req_tdata[8];

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || rsp_free;
   assign csr_ready  = 1'b1;

   l1wt_decide u_decide (
      .req           (s1_req_ff),
      .tstate_bypass (bypass_ff),
      .rsp           (decided)
   );

   always_comb begin
      s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
      s1_req_in    = (req_tready && req_tvalid) ? req_beat : s1_req_ff;
      rsp_valid_in = rsp_free ? s1_valid_ff : rsp_valid_ff;
      rsp_in       = (rsp_free && s1_valid_ff) ? decided : rsp_ff;
      bypass_in    = csr_valid ? csr_data : bypass_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bypass_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         bypass_ff    <= bypass_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0,
                        rsp_ff.prefetch_mark,
                        rsp_ff.release_writeback,
                        rsp_ff.fill_and_drain,
                        rsp_ff.enqueue_mshr,
                        rsp_ff.mshr_alloc,
                        rsp_ff.insert_line,
                        rsp_ff.up_msg,
                        rsp_ff.down_addr_only,
                        rsp_ff.down_msg,
                        rsp_ff.protocol_error,
                        rsp_ff.stall_res,
                        rsp_ff.line_next};

   // A decided request always lands in the result register
   a_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_free |=> rsp_tvalid)
      else $error("decided request lost before the result register");

   // Line insert is only ever ordered for a line that is not present
   a_insert_np: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && decided.insert_line |-> s1_req_ff.line_state == LS_NOT_PRESENT)
      else $error("line insert ordered for a present line");

   // A configuration beat sets the bypass control
   a_csr_write: assert property (@(posedge clock)
      !reset && csr_valid |=> reset || bypass_ff == $past(csr_data))
      else $error("tstate_bypass not updated by configuration beat");

endmodule

`default_nettype wire

/* hdl/l1wt_decide.sv */
// Per-line coherence decision: event and line state in, next state and commands out.
`default_nettype none

module l1wt_decide
   import l1wt_pkg::*;
(
   input  req_type req,
   input  logic    tstate_bypass,
   output rsp_type rsp
);

   ev_type    ev;
   logic      ts;
   logic      err;
   stall_type stall;
   stall_type miss_stall;
   logic      need_insert;
   rsp_type   work;

   assign ts = tstate_bypass & req.thread_state;

   always_comb begin
      unique case (req.command)
         CMD_READ:  ev = ts ? EV_TLD : EV_LD;
         CMD_WRITE: ev = ts ? EV_TST : EV_ST;
         CMD_RESP:  ev = ts ? EV_TRESP : EV_RESP;
         CMD_INV:   ev = EV_INV;
         CMD_WCOMP: ev = EV_WC;
         CMD_REPL:  ev = EV_REPL;
         default:   ev = EV_BAD;
      endcase
   end

   // Miss stall: allocator first (only when a line is needed), then MSHR readiness
   assign need_insert = (req.line_state == LS_NOT_PRESENT);

   always_comb begin
      if (need_insert && req.insert_status != INS_OK) begin
         miss_stall = (req.insert_status == INS_RETRY) ? STALL_POLL : STALL_WAIT;
      end else if (!req.mshr_free || !req.mshr_queue_room) begin
         miss_stall = STALL_POLL;
      end else begin
         miss_stall = STALL_NONE;
      end
   end

   always_comb begin
      work            = '0;
      work.line_next  = req.line_state;
      err             = 1'b0;
      stall           = STALL_NONE;

      if (ev == EV_BAD) begin
         err = 1'b1;
      end else begin
         case (req.line_state)
            LS_NOT_PRESENT, LS_INVALID: begin
               if (ev == EV_LD || ev == EV_ST) begin
                  if (miss_stall != STALL_NONE) begin
                     stall = miss_stall;
                  end else begin
                     work.insert_line     = need_insert;
                     work.mshr_alloc      = 1'b1;
                     work.enqueue_mshr    = 1'b1;
                     work.down_msg        = (ev == EV_LD) ? DN_READ : DN_READX;
                     work.down_addr_only  = (ev == EV_LD) || need_insert;
                     work.line_next       = LS_INV_TO_SH;
                     work.prefetch_mark   = req.prefetch_req;
                  end
               end else if (need_insert && ev == EV_INV) begin
                  // nothing cached: drop the invalidate
               end else if (need_insert && ev == EV_TLD) begin
                  work.down_msg       = DN_READ;
                  work.down_addr_only = 1'b1;
               end else if (need_insert && ev == EV_TST) begin
                  work.down_msg       = DN_READX;
                  work.down_addr_only = 1'b1;
               end else if (need_insert && ev == EV_TRESP) begin
                  work.up_msg = UP_DATA;
               end else begin
                  err = 1'b1;
               end
            end
            LS_INV_TO_SH: begin
               if (ev == EV_RESP || ev == EV_WC) begin
                  work.fill_and_drain = 1'b1;
                  work.line_next      = LS_SHARED;
               end else if (ev == EV_INV) begin
                  stall = STALL_WAIT;
               end else if (ev == EV_LD || ev == EV_ST) begin
                  if (!req.mshr_queue_room) begin
                     stall = STALL_POLL;
                  end else begin
                     work.enqueue_mshr = 1'b1;
                  end
               end else begin
                  err = 1'b1;
               end
            end
            LS_SHARED: begin
               if (ev == EV_LD) begin
                  work.up_msg = UP_DATA;
               end else if (ev == EV_ST) begin
                  work.down_msg   = DN_READX;
                  work.up_msg     = UP_DATA;
                  work.line_next  = LS_PEND_WRITE;
               end else if (ev == EV_REPL) begin
                  work.down_msg       = DN_REPL;
                  work.down_addr_only = 1'b1;
                  work.line_next      = LS_INVALID;
               end else if (ev == EV_INV) begin
                  work.up_msg     = UP_INVN;
                  work.down_msg   = DN_INVACK;
                  work.line_next  = LS_INVALID;
               end
            end
            LS_PEND_WRITE: begin
               if (ev == EV_LD) begin
                  work.up_msg = UP_DATA;
               end else if (ev == EV_ST) begin
                  stall = STALL_WAIT;
               end else if (ev == EV_WC) begin
                  work.line_next = LS_SHARED;
               end else begin
                  err = 1'b1;
               end
            end
            LS_SH_TO_INV: begin
               if (ev == EV_LD || ev == EV_ST) begin
                  stall = STALL_WAIT;
               end else if (ev == EV_INV) begin
                  work.release_writeback = 1'b1;
                  work.line_next         = LS_INVALID;
               end else begin
                  err = 1'b1;
               end
            end
            default: begin
               err = 1'b1;
            end
         endcase
      end
   end

   // Stall or error: hold the state and drop every command
   always_comb begin
      if (err || stall != STALL_NONE) begin
         rsp                = '0;
         rsp.line_next      = req.line_state;
         rsp.stall_res      = stall;
         rsp.protocol_error = err;
      end else begin
         rsp = work;
      end
   end

endmodule

`default_nettype wire
